### sv/brrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brrl_pkg: shared types and constants for the runtime rate learner
// Field types, register reset values, arithmetic constants, unit status.
// ----------------------------------------------------------------------------
package brrl_pkg;

    // field types
    typedef logic signed [7:0] t_pct;
    typedef logic [31:0]       t_ms;
    typedef logic [16:0]       t_minutes;
    typedef logic [15:0]       t_rate16;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    localparam int RATE_BITS_DEF = 16;

    // serial units
    localparam int DIV_DVW = 10;   // divisor width: step count, 1000 or 60
    localparam int MUL_XW  = 7;    // percent factor width, 0..100

    // configuration port
    localparam int   CFG_AW      = 3;
    localparam logic REG_MIN_IDX = 1'b0;
    localparam logic REG_MAX_IDX = 1'b1;

    localparam t_ms CFG_MIN_RST = 32'd10000;
    localparam t_ms CFG_MAX_RST = 32'd14400000;

    localparam logic [DIV_DVW-1:0] MS_PER_SEC  = 10'd1000;
    localparam logic [DIV_DVW-1:0] SEC_PER_MIN = 10'd60;

    localparam t_pct               PCT_FULL   = 8'sd100;
    localparam logic [MUL_XW-1:0]  PCT_FULL_U = 7'd100;
    localparam t_minutes           MINUTES_MAX = 17'd131071;

endpackage

`default_nettype wire

### sv/brrl_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brrl_in_if: gauge sample channel
// valid/ready handshake carrying one fuel-gauge sample word.
// ----------------------------------------------------------------------------
interface brrl_in_if;
    logic              valid;
    logic              ready;
    brrl_pkg::t_pct    percent;
    logic              charging;
    logic              supply_present;
    brrl_pkg::t_ms     time_ms;

    modport source (output valid, output percent, output charging,
                    output supply_present, output time_ms, input ready);
    modport sink   (input valid, input percent, input charging,
                    input supply_present, input time_ms, output ready);
endinterface

`default_nettype wire

### sv/brrl_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brrl_out_if: estimate result channel
// valid/ready handshake carrying one runtime estimate word.
// ----------------------------------------------------------------------------
interface brrl_out_if;
    logic                 valid;
    logic                 ready;
    brrl_pkg::t_minutes   minutes_left;
    logic                 estimate_known;
    logic                 rate_changed;
    logic                 changed_is_charge;
    brrl_pkg::t_rate16    changed_rate;

    modport source (output valid, output minutes_left, output estimate_known,
                    output rate_changed, output changed_is_charge,
                    output changed_rate, input ready);
    modport sink   (input valid, input minutes_left, input estimate_known,
                    input rate_changed, input changed_is_charge,
                    input changed_rate, output ready);
endinterface

`default_nettype wire

### sv/brrl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brrl_div: serial restoring divider
// Two quotient bits per cycle; narrow divisor and remainder.
// ----------------------------------------------------------------------------
module brrl_div #(
    parameter int DW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [brrl_pkg::DIV_DVW-1:0]  i_divisor,
    output logic [DW-1:0]                 o_quot,
    output brrl_pkg::t_unit_sts           o_sts
);
    import brrl_pkg::*;

    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DW-1:0]      r_quot;
    logic [DIV_DVW-1:0] r_rem;
    logic [DIV_DVW-1:0] r_div;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_DVW:0]   rem_a, rem_b;
    logic               ge_a, ge_b;
    logic [DIV_DVW-1:0] rem_a2, rem_b2;

    // two dependent restoring steps
    always_comb begin
        rem_a  = {r_rem, r_quot[DW-1]};
        ge_a   = rem_a >= {1'b0, r_div};
        rem_a2 = ge_a ? DIV_DVW'(rem_a - {1'b0, r_div}) : rem_a[DIV_DVW-1:0];
        rem_b  = {rem_a2, r_quot[DW-2]};
        ge_b   = rem_b >= {1'b0, r_div};
        rem_b2 = ge_b ? DIV_DVW'(rem_b - {1'b0, r_div}) : rem_b[DIV_DVW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-3:0], ge_a, ge_b};
            r_rem  <= rem_b2;
        end
    end

    assign o_quot     = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

### sv/brrl_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brrl_mul: serial shift-add multiplier
// Percent factor times rate, one factor bit per cycle.
// ----------------------------------------------------------------------------
module brrl_mul #(
    parameter int RATE_BITS = brrl_pkg::RATE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [brrl_pkg::MUL_XW-1:0]           i_factor,
    input  logic [RATE_BITS-1:0]                  i_rate,
    output logic [RATE_BITS+brrl_pkg::MUL_XW-1:0] o_prod,
    output brrl_pkg::t_unit_sts                   o_sts
);
    import brrl_pkg::*;

    localparam int PW = RATE_BITS + MUL_XW;
    localparam int CW = $clog2(MUL_XW + 1);

    logic [PW-1:0]     r_acc;
    logic [PW-1:0]     r_mcand;
    logic [MUL_XW-1:0] r_mplier;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MUL_XW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PW'(i_rate);
            r_mplier <= i_factor;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MUL_XW-1:1]};
        end
    end

    assign o_prod     = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

### sv/battery_runtime_rate_learner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_runtime_rate_learner_top: learned battery runtime estimator
// Learns seconds per percent for charge and discharge, reports minutes left.
// ----------------------------------------------------------------------------
// One sample word in gives one result word out. The block works on one sample
// at a time; most of its time goes to the shared serial divider, which retires
// two quotient bits per cycle and runs up to three times per sample (elapsed
// time by step count, interval by 1000, rate product by 60), plus the serial
// multiplier and a sequencer state each for accept, decide, update, estimate
// setup and result load. A finished result sits in an output register, so the
// next sample can be taken while the last result waits; a result that finds
// the output register still full holds the sequencer until it drains.
// Both learned rates start at zero (not learned); the first valid interval
// is taken as is, later ones blend 3/4 old with 1/4 new. Configuration
// (min/max ms per percent step at byte offsets 0 and 4) is to be written by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module battery_runtime_rate_learner_top #(
    parameter int RATE_BITS = brrl_pkg::RATE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    brrl_in_if.sink                      i_sample,
    brrl_out_if.source                   o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brrl_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import brrl_pkg::*;

    // divider width: holds 32-bit times and the percent*rate product, even
    localparam int DW = (RATE_BITS + 8 > 32) ? ((RATE_BITS + 9) / 2) * 2 : 32;
    localparam int PW = RATE_BITS + MUL_XW;
    localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_DIV_STEP = 4'd2;
    localparam logic [3:0] S_DIV_SEC  = 4'd3;
    localparam logic [3:0] S_UPDATE   = 4'd4;
    localparam logic [3:0] S_EST      = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_DIV_MIN  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    // ---------------- configuration ----------------
    t_ms r_cfg_min, r_cfg_max;
    logic cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_IDX) ? r_cfg_max : r_cfg_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min <= CFG_MIN_RST;
            r_cfg_max <= CFG_MAX_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_IDX) begin
                r_cfg_max <= pwdata;
            end else begin
                r_cfg_min <= pwdata;
            end
        end
    end

    // ---------------- state ----------------
    logic [3:0]            r_state, n_state;
    t_pct                  r_pct, n_pct;          // captured sample
    logic                  r_pwr, n_pwr;
    t_ms                   r_now, n_now;
    t_pct                  r_anc_pct, n_anc_pct;  // anchor
    t_ms                   r_anc_time, n_anc_time;
    logic                  r_anc_pwr, n_anc_pwr;
    logic [RATE_BITS-1:0]  r_dis_rate, n_dis_rate;
    logic [RATE_BITS-1:0]  r_chg_rate, n_chg_rate;
    logic [RATE_BITS-1:0]  r_sec, n_sec;
    logic                  r_chg, n_chg;          // per-sample result
    logic                  r_which, n_which;
    logic [RATE_BITS-1:0]  r_val, n_val;
    t_minutes              r_mins, n_mins;
    logic                  r_known, n_known;
    logic                  r_o_valid, n_o_valid;  // output register
    t_minutes              r_o_mins, n_o_mins;
    logic                  r_o_known, n_o_known;
    logic                  r_o_chg, n_o_chg;
    logic                  r_o_is_chg, n_o_is_chg;
    t_rate16               r_o_rate, n_o_rate;

    // serial units
    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [DIV_DVW-1:0]    div_divisor;
    logic [DW-1:0]         div_quot;
    t_unit_sts             div_sts;
    logic                  mul_start;
    logic [MUL_XW-1:0]     mul_factor;
    logic [RATE_BITS-1:0]  mul_rate;
    logic [PW-1:0]         mul_prod;
    t_unit_sts             mul_sts;

    brrl_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_sts      (div_sts)
    );

    brrl_mul #(.RATE_BITS(RATE_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_factor (mul_factor),
        .i_rate   (mul_rate),
        .o_prod   (mul_prod),
        .o_sts    (mul_sts)
    );

    // ---------------- datapath helpers ----------------
    logic                  in_acc, out_take;
    logic [8:0]            d_steps;     // signed step count, power direction
    t_ms                   elapsed;
    t_ms                   per;
    logic [RATE_BITS-1:0]  cur_rate, nxt_rate, est_rate;
    logic [RATE_BITS+1:0]  blend;
    logic [MUL_XW-1:0]     pct_clip;

    assign in_acc   = i_sample.valid & i_sample.ready;
    assign out_take = r_o_valid & o_result.ready;

    always_comb begin
        d_steps  = r_pwr ? ({r_pct[7], r_pct} - {r_anc_pct[7], r_anc_pct})
                         : ({r_anc_pct[7], r_anc_pct} - {r_pct[7], r_pct});
        elapsed  = r_now - r_anc_time;
        per      = div_quot[31:0];
        cur_rate = r_pwr ? r_chg_rate : r_dis_rate;
        // 3*old + new, then /4
        blend    = {2'b00, cur_rate} + {1'b0, cur_rate, 1'b0} + {2'b00, r_sec};
        nxt_rate = (cur_rate == '0) ? r_sec : blend[RATE_BITS+1:2];
        pct_clip = (r_pct > PCT_FULL) ? PCT_FULL_U : r_pct[MUL_XW-1:0];
        est_rate = r_pwr ? r_chg_rate : r_dis_rate;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_pct      = r_pct;
        n_pwr      = r_pwr;
        n_now      = r_now;
        n_anc_pct  = r_anc_pct;
        n_anc_time = r_anc_time;
        n_anc_pwr  = r_anc_pwr;
        n_dis_rate = r_dis_rate;
        n_chg_rate = r_chg_rate;
        n_sec      = r_sec;
        n_chg      = r_chg;
        n_which    = r_which;
        n_val      = r_val;
        n_mins     = r_mins;
        n_known    = r_known;
        n_o_valid  = r_o_valid & ~out_take;
        n_o_mins   = r_o_mins;
        n_o_known  = r_o_known;
        n_o_chg    = r_o_chg;
        n_o_is_chg = r_o_is_chg;
        n_o_rate   = r_o_rate;

        div_start    = 1'b0;
        div_dividend = DW'(elapsed);
        div_divisor  = DIV_DVW'(d_steps[6:0]);
        mul_start    = 1'b0;
        mul_factor   = r_pwr ? (PCT_FULL_U - pct_clip) : pct_clip;
        mul_rate     = est_rate;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pct   = i_sample.percent;
                    n_pwr   = i_sample.charging | i_sample.supply_present;
                    n_now   = i_sample.time_ms;
                    n_chg   = 1'b0;
                    n_which = 1'b0;
                    n_val   = '0;
                    n_mins  = '0;
                    n_known = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_pct[7] || r_anc_pct[7] || (r_pwr != r_anc_pwr)) begin
                    // no battery, no anchor or power direction flipped
                    n_anc_pct  = r_pct;
                    n_anc_time = r_now;
                    n_anc_pwr  = r_pwr;
                    n_state    = S_EST;
                end else if (r_pct == r_anc_pct) begin
                    n_state = S_EST;
                end else if (d_steps[8] || (d_steps == '0)) begin
                    // moved the wrong way
                    n_anc_pct  = r_pct;
                    n_anc_time = r_now;
                    n_state    = S_EST;
                end else begin
                    div_start  = 1'b1;
                    n_anc_pct  = r_pct;
                    n_anc_time = r_now;
                    n_state    = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                if (div_sts.done) begin
                    if ((per < r_cfg_min) || (per > r_cfg_max)) begin
                        n_state = S_EST;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = DW'(per);
                        div_divisor  = MS_PER_SEC;
                        n_state      = S_DIV_SEC;
                    end
                end
            end
            S_DIV_SEC: begin
                if (div_sts.done) begin
                    if (div_quot == '0) begin
                        n_sec = RATE_BITS'(1);
                    end else if (div_quot > DW'(RATE_MAX)) begin
                        n_sec = RATE_MAX;
                    end else begin
                        n_sec = RATE_BITS'(div_quot);
                    end
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (nxt_rate != cur_rate) begin
                    if (r_pwr) begin
                        n_chg_rate = nxt_rate;
                    end else begin
                        n_dis_rate = nxt_rate;
                    end
                    n_chg   = 1'b1;
                    n_which = r_pwr;
                    n_val   = nxt_rate;
                end
                n_state = S_EST;
            end
            S_EST: begin
                if (r_pct[7]) begin
                    n_state = S_DONE;
                end else if (r_pwr && (pct_clip == PCT_FULL_U)) begin
                    n_known = 1'b1;
                    n_state = S_DONE;
                end else if (est_rate == '0) begin
                    n_state = S_DONE;
                end else begin
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(mul_prod);
                    div_divisor  = SEC_PER_MIN;
                    n_state      = S_DIV_MIN;
                end
            end
            S_DIV_MIN: begin
                if (div_sts.done) begin
                    n_mins  = (div_quot > DW'(MINUTES_MAX)) ? MINUTES_MAX
                                                            : t_minutes'(div_quot);
                    n_known = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_result.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_mins   = r_mins;
                    n_o_known  = r_known;
                    n_o_chg    = r_chg;
                    n_o_is_chg = r_which;
                    n_o_rate   = t_rate16'(r_val);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_anc_pct  <= -8'sd1;
            r_anc_time <= '0;
            r_anc_pwr  <= 1'b0;
            r_dis_rate <= '0;
            r_chg_rate <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_anc_pct  <= n_anc_pct;
            r_anc_time <= n_anc_time;
            r_anc_pwr  <= n_anc_pwr;
            r_dis_rate <= n_dis_rate;
            r_chg_rate <= n_chg_rate;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pct      <= n_pct;
        r_pwr      <= n_pwr;
        r_now      <= n_now;
        r_sec      <= n_sec;
        r_chg      <= n_chg;
        r_which    <= n_which;
        r_val      <= n_val;
        r_mins     <= n_mins;
        r_known    <= n_known;
        r_o_mins   <= n_o_mins;
        r_o_known  <= n_o_known;
        r_o_chg    <= n_o_chg;
        r_o_is_chg <= n_o_is_chg;
        r_o_rate   <= n_o_rate;
    end

    // ---------------- ports ----------------
    assign i_sample.ready             = (r_state == S_IDLE);
    assign o_result.valid             = r_o_valid;
    assign o_result.minutes_left      = r_o_mins;
    assign o_result.estimate_known    = r_o_known;
    assign o_result.rate_changed      = r_o_chg;
    assign o_result.changed_is_charge = r_o_is_chg;
    assign o_result.changed_rate      = r_o_rate;

`ifndef SYNTHESIS
    // shared divider is only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> (!mul_sts.busy && !div_sts.busy))
        else $error("multiplier started while a unit is busy");

    // an unchanged rate reports zero side fields
    a_nochg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.rate_changed) |->
            (o_result.changed_rate == '0 && !o_result.changed_is_charge))
        else $error("change fields set without a rate change");

    // an unknown estimate carries zero minutes
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.estimate_known) |->
            (o_result.minutes_left == '0))
        else $error("minutes set on unknown estimate");
`endif

endmodule

`default_nettype wire
